/* rtl/kpdc_pkg.sv */
// Package for the key press duration classifier.
// Holds the configuration register map, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps

package kpdc_pkg;

  // Scan tick period in milliseconds; the register reset values follow from it.
  localparam int TICK_MS = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CNT_W      = 8;
  localparam int VLT_W      = 12;

  // The held counter stops this many ticks past the very-long threshold, or at its all-ones maximum.
  localparam int HELD_MARGIN = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COUNT_CAP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SETTLE_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_RELEASE_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COUNT_CAP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SETTLE_TICKS = 3'd6;

  localparam logic [CNT_W-1:0] PRESS_COUNT_CAP_RST      = CNT_W'((2500 / TICK_MS) & 255);
  localparam logic [CNT_W-1:0] PRESS_SETTLE_TICKS_RST   = CNT_W'((150 / TICK_MS) & 255);
  localparam logic [CNT_W-1:0] LONG_TICKS_RST           = CNT_W'((1500 / TICK_MS) & 255);
  localparam logic [CNT_W-1:0] LONG_RELEASE_TICKS_RST   = CNT_W'((1450 / TICK_MS) & 255);
  localparam logic [VLT_W-1:0] VERY_LONG_TICKS_RST      = VLT_W'((6000 / TICK_MS) & 4095);
  localparam logic [CNT_W-1:0] RELEASE_COUNT_CAP_RST    = CNT_W'((300 / TICK_MS) & 255);
  localparam logic [CNT_W-1:0] RELEASE_SETTLE_TICKS_RST = CNT_W'((100 / TICK_MS) & 255);

  typedef struct packed {
    logic [CNT_W-1:0] press_count_cap;
    logic [CNT_W-1:0] press_settle_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] long_release_ticks;
    logic [VLT_W-1:0] very_long_ticks;
    logic [CNT_W-1:0] release_count_cap;
    logic [CNT_W-1:0] release_settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic short_flag;
    logic long_flag;
    logic very_long_flag;
  } flags_t;

endpackage

/* rtl/kpdc_if.sv */
// Channel interfaces of the key press duration classifier: input, result
// and configuration write. Depends on kpdc_pkg for the field widths.
`timescale 1ns / 1ps

interface kpdc_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic clear_events;

  modport source (output valid, output pin_level, output clear_events, input ready);
  modport sink   (input valid, input pin_level, input clear_events, output ready);
endinterface

interface kpdc_out_if;
  logic valid;
  logic ready;
  logic short_event;
  logic long_event;
  logic very_long_event;

  modport source (output valid, output short_event, output long_event,
                  output very_long_event, input ready);
  modport sink   (input valid, input short_event, input long_event,
                  input very_long_event, output ready);
endinterface

interface kpdc_cfg_if import kpdc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/kpdc_step.sv */
// Next-state logic for one scan tick: counters, thresholds and event flags.
// Depends on kpdc_pkg.
`timescale 1ns / 1ps

module kpdc_step import kpdc_pkg::*; #(
  parameter int HELD_COUNT_BITS = 12
) (
  input  cfg_t                       cfg,
  input  logic                       pin_level,
  input  logic                       clear_events,
  input  logic [CNT_W-1:0]           press_count,
  input  logic [CNT_W-1:0]           release_count,
  input  logic [HELD_COUNT_BITS-1:0] held_count,
  input  flags_t                     flags,
  output logic [CNT_W-1:0]           press_count_nxt,
  output logic [CNT_W-1:0]           release_count_nxt,
  output logic [HELD_COUNT_BITS-1:0] held_count_nxt,
  output flags_t                     flags_nxt
);

  // Wide enough for the held counter and for very_long_ticks plus the margin.
  localparam int LW = (HELD_COUNT_BITS > VLT_W + 1) ? HELD_COUNT_BITS : VLT_W + 1;

  logic [LW-1:0]              vlt_ext;
  logic [LW-1:0]              limit_raw;
  logic [LW-1:0]              held_max;
  logic [LW-1:0]              held_limit;
  logic [LW-1:0]              held_ext;
  logic [HELD_COUNT_BITS-1:0] held_inc;
  logic [LW-1:0]              held_inc_ext;
  logic [CNT_W-1:0]           press_inc;
  logic [CNT_W-1:0]           release_inc;

  always_comb begin
    vlt_ext      = LW'(cfg.very_long_ticks);
    limit_raw    = vlt_ext + LW'(HELD_MARGIN);
    held_max     = LW'({HELD_COUNT_BITS{1'b1}});
    held_limit   = (limit_raw > held_max) ? held_max : limit_raw;
    held_ext     = LW'(held_count);
    held_inc     = held_count + HELD_COUNT_BITS'(1);
    held_inc_ext = LW'(held_inc);
    press_inc    = press_count + CNT_W'(1);
    release_inc  = release_count + CNT_W'(1);
  end

  always_comb begin
    flags_nxt         = clear_events ? '0 : flags;
    press_count_nxt   = press_count;
    release_count_nxt = release_count;
    held_count_nxt    = held_count;

    if (!pin_level) begin
      if (press_count < cfg.press_count_cap) begin
        press_count_nxt = press_inc;
        if (press_inc >= cfg.press_settle_ticks) begin
          release_count_nxt = '0;
        end
        if (press_inc == cfg.long_ticks) begin
          flags_nxt.long_flag  = 1'b1;
          flags_nxt.short_flag = 1'b0;
        end
      end
      if (held_ext < held_limit) begin
        held_count_nxt = held_inc;
        if (held_inc_ext == vlt_ext) begin
          flags_nxt.very_long_flag = 1'b1;
          flags_nxt.long_flag      = 1'b0;
          flags_nxt.short_flag     = 1'b0;
        end
      end
    end else if (release_count < cfg.release_count_cap) begin
      release_count_nxt = release_inc;
      if (release_inc >= cfg.release_settle_ticks) begin
        // A long press only drops a pending short event, unless it went very long.
        if (press_count >= cfg.long_release_ticks) begin
          if (held_ext < vlt_ext) begin
            flags_nxt.short_flag = 1'b0;
          end
        end else if (press_count > cfg.press_settle_ticks) begin
          flags_nxt.short_flag = 1'b1;
          flags_nxt.long_flag  = 1'b0;
        end
        press_count_nxt = '0;
        held_count_nxt  = '0;
      end
    end
  end

endmodule

/* rtl/key_press_duration_classifier_core.sv */
// Top level of the key press duration classifier: channels, configuration
// registers, tick pipeline and state. Depends on kpdc_pkg, kpdc_if, kpdc_step.
`timescale 1ns / 1ps

// Each input beat is one scan tick of the active-low key pin plus a request
// to clear the sticky event flags; each tick returns exactly one result beat
// carrying the short, long and very-long flags as they stand after that tick.
// The block takes one tick per clock cycle while no result is stalled. A
// result beat is presented once its tick has passed through the input
// register, which holds it while a result is stalled; the counter and
// threshold logic then writes the state and the result register together.
// A stalled result stops the input side only once the input register is full
// as well. Configuration writes are taken in any cycle and should be made
// while no tick is in flight.

module key_press_duration_classifier_core import kpdc_pkg::*; #(
  parameter int HELD_COUNT_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  kpdc_in_if.sink     in_ch,
  kpdc_out_if.source  out_ch,
  kpdc_cfg_if.sink    cfg_ch
);

  cfg_t                       cfg_r;
  logic                       s1_valid_r;
  logic                       s1_pin_r;
  logic                       s1_clear_r;
  logic                       out_valid_r;
  logic [CNT_W-1:0]           press_count_r;
  logic [CNT_W-1:0]           release_count_r;
  logic [HELD_COUNT_BITS-1:0] held_count_r;
  flags_t                     flags_r;

  logic [CNT_W-1:0]           press_count_nxt;
  logic [CNT_W-1:0]           release_count_nxt;
  logic [HELD_COUNT_BITS-1:0] held_count_nxt;
  flags_t                     flags_nxt;

  logic s1_adv;
  logic in_ready;
  logic step_fire;

  assign s1_adv    = !out_valid_r || out_ch.ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign step_fire = s1_valid_r && s1_adv;

  assign in_ch.ready     = in_ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  // The flags only change when a new result enters the output register.
  assign out_ch.short_event     = flags_r.short_flag;
  assign out_ch.long_event      = flags_r.long_flag;
  assign out_ch.very_long_event = flags_r.very_long_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_count_cap      <= PRESS_COUNT_CAP_RST;
      cfg_r.press_settle_ticks   <= PRESS_SETTLE_TICKS_RST;
      cfg_r.long_ticks           <= LONG_TICKS_RST;
      cfg_r.long_release_ticks   <= LONG_RELEASE_TICKS_RST;
      cfg_r.very_long_ticks      <= VERY_LONG_TICKS_RST;
      cfg_r.release_count_cap    <= RELEASE_COUNT_CAP_RST;
      cfg_r.release_settle_ticks <= RELEASE_SETTLE_TICKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PRESS_COUNT_CAP:      cfg_r.press_count_cap      <= cfg_ch.data[CNT_W-1:0];
        REG_PRESS_SETTLE_TICKS:   cfg_r.press_settle_ticks   <= cfg_ch.data[CNT_W-1:0];
        REG_LONG_TICKS:           cfg_r.long_ticks           <= cfg_ch.data[CNT_W-1:0];
        REG_LONG_RELEASE_TICKS:   cfg_r.long_release_ticks   <= cfg_ch.data[CNT_W-1:0];
        REG_VERY_LONG_TICKS:      cfg_r.very_long_ticks      <= cfg_ch.data[VLT_W-1:0];
        REG_RELEASE_COUNT_CAP:    cfg_r.release_count_cap    <= cfg_ch.data[CNT_W-1:0];
        REG_RELEASE_SETTLE_TICKS: cfg_r.release_settle_ticks <= cfg_ch.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_pin_r   <= in_ch.pin_level;
      s1_clear_r <= in_ch.clear_events;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      press_count_r   <= '0;
      release_count_r <= '0;
      held_count_r    <= '0;
      flags_r         <= '0;
    end else if (step_fire) begin
      out_valid_r     <= 1'b1;
      press_count_r   <= press_count_nxt;
      release_count_r <= release_count_nxt;
      held_count_r    <= held_count_nxt;
      flags_r         <= flags_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  kpdc_step #(
    .HELD_COUNT_BITS(HELD_COUNT_BITS)
  ) u_step (
    .cfg               (cfg_r),
    .pin_level         (s1_pin_r),
    .clear_events      (s1_clear_r),
    .press_count       (press_count_r),
    .release_count     (release_count_r),
    .held_count        (held_count_r),
    .flags             (flags_r),
    .press_count_nxt   (press_count_nxt),
    .release_count_nxt (release_count_nxt),
    .held_count_nxt    (held_count_nxt),
    .flags_nxt         (flags_nxt)
  );

endmodule

/* rtl/kpdc_checker.sv */
// Port-level checker for the key press duration classifier core, with the
// bind that attaches it. Depends on key_press_duration_classifier_core.
`timescale 1ns / 1ps

module kpdc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_short,
  input logic out_long,
  input logic out_very_long
);

  // A result beat that is held back keeps its flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_short) && $stable(out_long)
      && $stable(out_very_long))
    else $error("result beat changed while stalled");

  // With the result register empty the pipeline always has room for a tick.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Reset leaves the block empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind key_press_duration_classifier_core kpdc_checker u_kpdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_short     (out_ch.short_event),
  .out_long      (out_ch.long_event),
  .out_very_long (out_ch.very_long_event)
);
